/* rtl/core/r2fft_pkg.sv */
// shared types, constants and twiddle lookup for the radix-2 fft unit
package r2fft_pkg;

  localparam int MaxPointsDefault = 64;
  localparam int RomLog           = 6;
  localparam int DataW            = 24;
  localparam int SampleW          = 16;
  localparam int TwW              = 17;
  localparam int ProdW            = TwW + DataW;
  localparam int SumW             = ProdW + 1;
  localparam int RoundShift       = 15;
  localparam int LgW              = 3;
  localparam int CfgIdxW          = 2;
  localparam int CfgDataW         = 8;
  localparam int BinIdxW          = 6;

  localparam logic [CfgIdxW-1:0] RegDirection = 2'd0;
  localparam logic [CfgIdxW-1:0] RegLog2      = 2'd1;

  typedef struct packed {
    logic signed [DataW-1:0] re;
    logic signed [DataW-1:0] im;
  } cplx_t;

  typedef struct packed {
    logic signed [TwW-1:0] wr;
    logic signed [TwW-1:0] wi;
  } twiddle_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_CAP,
    BS_M0,
    BS_M1,
    BS_M2,
    BS_M3,
    BS_M4
  } bf_step_t;

  localparam logic signed [TwW-1:0] QSin [0:16] = '{
    17'sd0,     17'sd3212,  17'sd6393,  17'sd9512,  17'sd12540, 17'sd15447,
    17'sd18205, 17'sd20788, 17'sd23170, 17'sd25330, 17'sd27246, 17'sd28899,
    17'sd30274, 17'sd31357, 17'sd32138, 17'sd32610, 17'sd32768
  };

  function automatic twiddle_t tw_lookup(logic [4:0] k, logic dir);
    logic signed [TwW-1:0] c;
    logic signed [TwW-1:0] s;
    twiddle_t w;
    if (k <= 5'd16) begin
      s = QSin[k];
      c = QSin[5'd16 - k];
    end else begin
      s = QSin[5'(6'd32 - {1'b0, k})];
      c = -QSin[5'(k - 5'd16)];
    end
    w.wr = c;
    w.wi = dir ? -s : s;
    return w;
  endfunction

endpackage

/* rtl/core/radix2_complex_fft_unit.sv */
// radix-2 decimation-in-time complex fft, top level with sequencer
// Samples load one word per cycle in natural order while in_ready is high; a frame ends on
// frame_end or when N = 2^log2_points samples are in. The unit is then busy: a bit-reverse
// pass over the points, then log2(N) stages of N/2 butterflies on one shared multiplier,
// then N bins, each held until out_ready, then a clearing pass over all MAX_POINTS
// entries of the point store. The same clearing pass runs after reset. Frame time is set
// by the single multiplier used for all four products of each butterfly.
module radix2_complex_fft_unit import r2fft_pkg::*; #(
  parameter int MAX_POINTS = MaxPointsDefault
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CfgIdxW-1:0]         cfg_index,
  input  logic [CfgDataW-1:0]        cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SampleW-1:0]  sample_re,
  input  logic signed [SampleW-1:0]  sample_im,
  input  logic                       frame_end,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [DataW-1:0]    bin_re,
  output logic signed [DataW-1:0]    bin_im,
  output logic [BinIdxW-1:0]         bin_index,
  output logic                       bin_last
);

  localparam int AW = $clog2(MAX_POINTS);

  typedef enum logic [4:0] {
    S_CLR, S_LOAD,
    S_BR_RD, S_BR_CAP, S_BR_WJ, S_BR_WI,
    S_BF_RD, S_BF_CAP, S_BF_M0, S_BF_M1, S_BF_M2, S_BF_M3, S_BF_M4, S_BF_WQ, S_BF_WP,
    S_OUT_RD, S_OUT_CAP, S_OUT_HOLD
  } state_t;

  state_t          state;
  logic            direction;
  logic [LgW-1:0]  log2_points;
  logic [AW:0]     load_count;
  logic [LgW-1:0]  lg_run;
  logic [LgW-1:0]  stage;
  logic [AW-1:0]   cnt;
  cplx_t           hold0;
  cplx_t           hold1;
  twiddle_t        tw;

  logic [LgW-1:0]  lg_eff;
  logic [AW:0]     n_eff;
  logic [AW:0]     n_run;
  logic [AW-1:0]   last_pt;
  logic [AW-1:0]   last_bf;
  logic [AW-1:0]   rev_full;
  logic [AW-1:0]   cnt_rev;
  logic [AW:0]     hmask;
  logic [AW:0]     p_ext;
  logic [AW-1:0]   p_addr;
  logic [AW-1:0]   q_addr;
  logic [AW-1:0]   tw_k;
  logic [4:0]      tw_idx;
  logic            in_acc;
  logic            fire;

  logic            we;
  logic [AW-1:0]   waddr;
  cplx_t           wdata;
  logic [AW-1:0]   raddr0;
  logic [AW-1:0]   raddr1;
  cplx_t           rdata0;
  cplx_t           rdata1;
  bf_step_t        step;
  cplx_t           bf_sum;
  cplx_t           bf_diff;
  cplx_t           sample;

  always_comb begin
    if (log2_points == '0) begin
      lg_eff = LgW'(1);
    end else if (log2_points > LgW'(AW)) begin
      lg_eff = LgW'(AW);
    end else begin
      lg_eff = log2_points;
    end
  end

  assign n_eff   = (AW+1)'(1) << lg_eff;
  assign n_run   = (AW+1)'(1) << lg_run;
  assign last_pt = AW'(n_run - (AW+1)'(1));
  assign last_bf = AW'((n_run >> 1) - (AW+1)'(1));

  always_comb begin
    for (int b = 0; b < AW; b++) begin
      rev_full[b] = cnt[AW-1-b];
    end
  end
  assign cnt_rev = rev_full >> (LgW'(AW) - lg_run);

  assign hmask  = ((AW+1)'(1) << (stage - LgW'(1))) - (AW+1)'(1);
  assign p_ext  = ((({1'b0, cnt}) >> (stage - LgW'(1))) << stage) | ({1'b0, cnt} & hmask);
  assign p_addr = AW'(p_ext);
  assign q_addr = AW'(p_ext | (hmask + (AW+1)'(1)));
  assign tw_k   = AW'({1'b0, cnt} & hmask);
  assign tw_idx = 5'((RomLog+1)'(tw_k) << (LgW'(RomLog) - stage));

  assign in_ready  = (state == S_LOAD);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign fire      = (load_count >= n_eff) || frame_end ||
                     (load_count + (AW+1)'(1) >= n_eff);

  assign sample.re = DataW'(sample_re);
  assign sample.im = DataW'(sample_im);

  always_comb begin
    we     = 1'b0;
    waddr  = cnt;
    wdata  = '0;
    raddr0 = cnt;
    raddr1 = cnt_rev;
    step   = BS_IDLE;
    case (state)
      S_CLR: we = 1'b1;
      S_LOAD: begin
        we    = in_acc && (load_count < n_eff);
        waddr = AW'(load_count);
        wdata = sample;
      end
      S_BR_WJ: begin
        we    = 1'b1;
        waddr = cnt_rev;
        wdata = hold0;
      end
      S_BR_WI: begin
        we    = 1'b1;
        wdata = hold1;
      end
      S_BF_RD: begin
        raddr0 = p_addr;
        raddr1 = q_addr;
      end
      S_BF_CAP: step = BS_CAP;
      S_BF_M0:  step = BS_M0;
      S_BF_M1:  step = BS_M1;
      S_BF_M2:  step = BS_M2;
      S_BF_M3:  step = BS_M3;
      S_BF_M4:  step = BS_M4;
      S_BF_WQ: begin
        we    = 1'b1;
        waddr = q_addr;
        wdata = bf_diff;
      end
      S_BF_WP: begin
        we    = 1'b1;
        waddr = p_addr;
        wdata = bf_sum;
      end
      default: ;
    endcase
  end

  r2fft_ram #(
    .WIDTH ($bits(cplx_t)),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  r2fft_bfly u_bfly (
    .clk  (clk),
    .step (step),
    .a_in (rdata0),
    .x_in (rdata1),
    .w    (tw),
    .sum  (bf_sum),
    .diff (bf_diff)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      cnt         <= '0;
      load_count  <= '0;
      direction   <= 1'b0;
      log2_points <= LgW'(6);
      lg_run      <= LgW'(1);
      stage       <= LgW'(1);
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegDirection: direction   <= cfg_data[0];
          RegLog2:      log2_points <= cfg_data[LgW-1:0];
          default: ;
        endcase
      end
      case (state)
        S_CLR: begin
          cnt <= cnt + AW'(1);
          if (cnt == AW'(MAX_POINTS - 1)) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (in_acc) begin
            if (load_count < n_eff) begin
              load_count <= load_count + (AW+1)'(1);
            end
            if (fire) begin
              lg_run <= lg_eff;
              cnt    <= '0;
              state  <= S_BR_RD;
            end
          end
        end
        S_BR_RD: begin
          if (cnt < cnt_rev) begin
            state <= S_BR_CAP;
          end else if (cnt == last_pt) begin
            cnt   <= '0;
            stage <= LgW'(1);
            state <= S_BF_RD;
          end else begin
            cnt <= cnt + AW'(1);
          end
        end
        S_BR_CAP: begin
          hold0 <= rdata0;
          hold1 <= rdata1;
          state <= S_BR_WJ;
        end
        S_BR_WJ: state <= S_BR_WI;
        S_BR_WI: begin
          cnt   <= cnt + AW'(1);
          state <= S_BR_RD;
        end
        S_BF_RD: state <= S_BF_CAP;
        S_BF_CAP: begin
          tw    <= tw_lookup(tw_idx, direction);
          state <= S_BF_M0;
        end
        S_BF_M0: state <= S_BF_M1;
        S_BF_M1: state <= S_BF_M2;
        S_BF_M2: state <= S_BF_M3;
        S_BF_M3: state <= S_BF_M4;
        S_BF_M4: state <= S_BF_WQ;
        S_BF_WQ: state <= S_BF_WP;
        S_BF_WP: begin
          if (cnt == last_bf) begin
            cnt <= '0;
            if (stage == lg_run) begin
              state <= S_OUT_RD;
            end else begin
              stage <= stage + LgW'(1);
              state <= S_BF_RD;
            end
          end else begin
            cnt   <= cnt + AW'(1);
            state <= S_BF_RD;
          end
        end
        S_OUT_RD: state <= S_OUT_CAP;
        S_OUT_CAP: begin
          bin_re    <= rdata0.re;
          bin_im    <= rdata0.im;
          bin_index <= BinIdxW'(cnt);
          bin_last  <= (cnt == last_pt);
          out_valid <= 1'b1;
          state     <= S_OUT_HOLD;
        end
        S_OUT_HOLD: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (bin_last) begin
              cnt        <= '0;
              load_count <= '0;
              state      <= S_CLR;
            end else begin
              cnt   <= cnt + AW'(1);
              state <= S_OUT_RD;
            end
          end
        end
        default: state <= S_CLR;
      endcase
    end
  end

  a_no_load_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while a bin is pending");

  a_last_bin_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && bin_last) |-> (bin_index == BinIdxW'(last_pt)))
    else $error("last flag on wrong bin");

  a_clear_after_frame: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && bin_last) |=> (!in_ready && load_count == '0))
    else $error("store not cleared after frame");

endmodule

/* rtl/core/r2fft_ram.sv */
// generic ram, one write port, two registered read ports
module r2fft_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

/* rtl/core/r2fft_bfly.sv */
// shared butterfly datapath, one multiplier reused over four steps
module r2fft_bfly import r2fft_pkg::*; (
  input  logic     clk,
  input  bf_step_t step,
  input  cplx_t    a_in,
  input  cplx_t    x_in,
  input  twiddle_t w,
  output cplx_t    sum,
  output cplx_t    diff
);

  cplx_t                   a;
  cplx_t                   x;
  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] acc;
  logic signed [DataW-1:0] tr;
  logic signed [DataW-1:0] ti;
  logic signed [TwW-1:0]   mop_w;
  logic signed [DataW-1:0] mop_x;
  logic signed [SumW-1:0]  s_re;
  logic signed [SumW-1:0]  s_im;

  always_comb begin
    case (step)
      BS_M0:   begin mop_w = w.wr; mop_x = x.re; end
      BS_M1:   begin mop_w = w.wi; mop_x = x.im; end
      BS_M2:   begin mop_w = w.wr; mop_x = x.im; end
      BS_M3:   begin mop_w = w.wi; mop_x = x.re; end
      default: begin mop_w = w.wr; mop_x = x.re; end
    endcase
  end

  // round to nearest, ties up
  assign s_re = SumW'(acc) - SumW'(prod) + SumW'(1 << (RoundShift - 1));
  assign s_im = SumW'(acc) + SumW'(prod) + SumW'(1 << (RoundShift - 1));

  always_ff @(posedge clk) begin
    prod <= mop_w * mop_x;
    case (step)
      BS_CAP: begin
        a <= a_in;
        x <= x_in;
      end
      BS_M1:   acc <= prod;
      BS_M2:   tr  <= s_re[RoundShift+DataW-1:RoundShift];
      BS_M3:   acc <= prod;
      BS_M4:   ti  <= s_im[RoundShift+DataW-1:RoundShift];
      default: ;
    endcase
  end

  assign sum.re  = a.re + tr;
  assign sum.im  = a.im + ti;
  assign diff.re = a.re - tr;
  assign diff.im = a.im - ti;

endmodule
